// ===== sv/rnta_pkg.sv =====
// Shared types and constants for the radix number to ASCII converter.
// No dependencies; imported by every module of the block.
package rnta_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int RADIX_W        = 5;
  localparam int CHAR_W         = 7;
  localparam int DIGIT_W        = 4;
  // Quotient bits resolved per divider cycle.
  localparam int DIV_BITS       = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  localparam int STEP_W = 2;
  typedef logic [STEP_W-1:0] step_t;

  // Microprogram addresses.
  localparam step_t STEP_IDLE = 2'd0;
  localparam step_t STEP_DIV  = 2'd1;
  localparam step_t STEP_PUSH = 2'd2;
  localparam step_t STEP_EMIT = 2'd3;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  typedef enum logic [1:0] {
    ACT_LOAD,
    ACT_DIV,
    ACT_PUSH,
    ACT_EMIT
  } act_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_DIV_MORE,
    COND_QUOT_NZ,
    COND_STACK_MORE
  } cond_t;

  typedef struct packed {
    wait_t wait_on;
    act_t  act;
    cond_t cond;
    step_t target;
  } uword_t;

  // Datapath status back to the sequencer.
  typedef struct packed {
    logic in_go;
    logic out_go;
    logic div_more;
    logic quot_nz;
    logic stack_more;
  } flags_t;

endpackage

// ===== sv/rnta_ucode.sv =====
// Microcode sequencer: step counter, control ROM and branch logic.
// Depends on rnta_pkg.
module rnta_ucode (
  input  logic              clk,
  input  logic              rst,
  input  rnta_pkg::flags_t  flags,
  output rnta_pkg::uword_t  uword,
  output logic              exec
);
  import rnta_pkg::*;

  localparam uword_t ROM [4] = '{
    '{wait_on: WAIT_IN,   act: ACT_LOAD, cond: COND_NEVER,      target: STEP_IDLE},
    '{wait_on: WAIT_NONE, act: ACT_DIV,  cond: COND_DIV_MORE,   target: STEP_DIV},
    '{wait_on: WAIT_NONE, act: ACT_PUSH, cond: COND_QUOT_NZ,    target: STEP_DIV},
    '{wait_on: WAIT_OUT,  act: ACT_EMIT, cond: COND_STACK_MORE, target: STEP_EMIT}
  };

  step_t step;
  step_t step_next;
  logic  taken;

  assign uword = ROM[step];

  always_comb begin
    unique case (uword.wait_on)
      WAIT_NONE: exec = 1'b1;
      WAIT_IN:   exec = flags.in_go;
      WAIT_OUT:  exec = flags.out_go;
      default:   exec = 1'b0;
    endcase

    unique case (uword.cond)
      COND_NEVER:      taken = 1'b0;
      COND_DIV_MORE:   taken = flags.div_more;
      COND_QUOT_NZ:    taken = flags.quot_nz;
      COND_STACK_MORE: taken = flags.stack_more;
      default:         taken = 1'b0;
    endcase

    // Falling through the last word wraps back to idle.
    if (!exec) begin
      step_next = step;
    end else if (taken) begin
      step_next = uword.target;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== sv/rnta_datapath.sv =====
// Datapath: radix divider (several quotient bits per cycle), digit stack,
// output register. Driven by control words from rnta_ucode; uses rnta_pkg.
module rnta_datapath #(
  parameter int VALUE_BITS = rnta_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rnta_pkg::uword_t              uword,
  input  logic                          exec,
  input  logic                          in_valid,
  input  logic [VALUE_BITS-1:0]         value,
  input  logic [rnta_pkg::RADIX_W-1:0]  radix,
  output rnta_pkg::flags_t              flags,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rnta_pkg::CHAR_W-1:0]   character,
  output logic                          last
);
  import rnta_pkg::*;

  localparam int DIV_W     = ((VALUE_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int DEPTH_W   = $clog2(VALUE_BITS + 1);

  logic [DIV_W-1:0]   sh;
  logic [DIV_W-1:0]   sh_next;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] rem_next;
  logic [RADIX_W-1:0] rad;
  logic [RADIX_W-1:0] rad_clamped;
  logic [CNT_W-1:0]   cnt;
  logic [DEPTH_W-1:0] depth;
  logic [DIGIT_W-1:0] stk [VALUE_BITS];

  always_comb begin
    if (radix < RADIX_MIN) begin
      rad_clamped = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      rad_clamped = RADIX_MAX;
    end else begin
      rad_clamped = radix;
    end
  end

  // Restoring division, DIV_BITS quotient bits per cycle; quotient shifts
  // into the low end of sh as the dividend shifts out the top.
  always_comb begin
    logic [RADIX_W-1:0] t;
    logic               ge;
    rem_next = rem;
    sh_next  = sh;
    for (int i = 0; i < DIV_BITS; i++) begin
      t  = {rem_next, sh_next[DIV_W-1]};
      ge = (t >= rad);
      if (ge) begin
        rem_next = DIGIT_W'(t - rad);
      end else begin
        rem_next = t[DIGIT_W-1:0];
      end
      sh_next = {sh_next[DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      unique case (uword.act)
        ACT_LOAD: begin
          sh  <= DIV_W'(value);
          rad <= rad_clamped;
          rem <= '0;
          cnt <= CNT_W'(DIV_STEPS);
        end
        ACT_DIV: begin
          sh  <= sh_next;
          rem <= rem_next;
          cnt <= cnt - CNT_W'(1);
        end
        ACT_PUSH: begin
          rem <= '0;
          cnt <= CNT_W'(DIV_STEPS);
        end
        ACT_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Digit stack as a shift line; top is always entry 0.
  always_ff @(posedge clk) begin
    if (exec && uword.act == ACT_PUSH) begin
      stk[0] <= rem;
      for (int i = 1; i < VALUE_BITS; i++) begin
        stk[i] <= stk[i-1];
      end
    end else if (exec && uword.act == ACT_EMIT) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stk[i] <= stk[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (exec) begin
      unique case (uword.act)
        ACT_LOAD: depth <= '0;
        ACT_PUSH: depth <= depth + DEPTH_W'(1);
        ACT_EMIT: depth <= depth - DEPTH_W'(1);
        default:  depth <= depth;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec && uword.act == ACT_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && uword.act == ACT_EMIT) begin
      character <= DIGIT_CHARS[stk[0]];
      last      <= (depth == DEPTH_W'(1));
    end
  end

  assign flags.in_go      = in_valid;
  assign flags.out_go     = !out_valid || !out_stall;
  assign flags.div_more   = (cnt > CNT_W'(1));
  assign flags.quot_nz    = |sh;
  assign flags.stack_more = (depth > DEPTH_W'(1));

endmodule

// ===== sv/radix_number_to_ascii.sv =====
// Channel   Handshake            Payload           Moves per transfer
// input     in_valid/in_stall    value, radix      one number to convert
// output    out_valid/out_stall  character, last   one ASCII digit, MSD first
//
// An item takes a load step, then for each of its D digits S = ceil(VALUE_BITS/4)
// divider steps and a push (S = 4 at 16 bits), then one emit step per digit.
// The shared divider, resolving four quotient bits a cycle, sets the pace.
// Synchronous active-high reset returns the sequencer to idle, output empty.
// A new number is taken only when idle; the final digit may still sit in the
// output register then. Output stalls hold the sequencer on the emit step.
module radix_number_to_ascii #(
  parameter int VALUE_BITS = rnta_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [VALUE_BITS-1:0]         value,
  input  logic [rnta_pkg::RADIX_W-1:0]  radix,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rnta_pkg::CHAR_W-1:0]   character,
  output logic                          last
);
  import rnta_pkg::*;

  uword_t uword;
  flags_t flags;
  logic   exec;

  assign in_stall = (uword.wait_on != WAIT_IN);

  rnta_ucode u_ucode (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uword (uword),
    .exec  (exec)
  );

  rnta_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .uword     (uword),
    .exec      (exec),
    .in_valid  (in_valid),
    .value     (value),
    .radix     (radix),
    .flags     (flags),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

endmodule

// ===== sv/rnta_checker.sv =====
// Port-level checks for radix_number_to_ascii, bound to the top level.
// Depends on rnta_pkg.
module rnta_checker #(
  parameter int VALUE_BITS = rnta_pkg::VALUE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [VALUE_BITS-1:0]         value,
  input logic [rnta_pkg::RADIX_W-1:0]  radix,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rnta_pkg::CHAR_W-1:0]   character,
  input logic                          last
);
  import rnta_pkg::*;

  // Stalled output holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(character) && $stable(last))
    else $error("stalled output changed");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character >= 7'h30 && character <= 7'h39) ||
                  (character >= 7'h41 && character <= 7'h46))
    else $error("output character is not a digit");

  // Input is stalled in the cycle after an input transfer.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // While ready for input, only the final digit of a run may be pending.
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    !in_stall && out_valid |-> last)
    else $error("ready for input with digits still pending");

endmodule

bind radix_number_to_ascii rnta_checker #(.VALUE_BITS(VALUE_BITS)) u_rnta_checker (.*);
